// File: src/rfq_pkg.sv
// Shared types and constants of the framed byte queue transmitter.
`default_nettype none

package rfq_pkg;

    // Request kinds carried in s_tuser.
    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_EOP  = 2'd1,
        REQ_SLOT = 2'd2,
        REQ_NONE = 2'd3
    } rfq_req_t;

    // Packet status codes.
    typedef enum logic [1:0] {
        STAT_QUEUED   = 2'd0,
        STAT_TOO_LONG = 2'd1,
        STAT_NO_ROOM  = 2'd2
    } rfq_status_t;

    // Result kinds carried in m_tuser.
    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_BYTE   = 1'b1
    } rfq_kind_t;

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_MAX_PAYLOAD = 1'b0,
        REG_CHUNK_LIMIT = 1'b1
    } rfq_reg_t;

    // Control towards the byte queue.
    typedef struct packed {
        logic push;
        logic pop;
    } rfq_q_ctrl_t;

    // Control towards the CRC unit.
    typedef struct packed {
        logic clear;
        logic start;
    } rfq_crc_ctrl_t;

    localparam logic [7:0] FRAME_HEAD     = 8'hAA;
    localparam logic [7:0] FRAME_TAIL     = 8'hAD;
    localparam int         FRAME_OVERHEAD = 5;
    localparam logic [7:0] CRC_POLY_REFL  = 8'h8C;
    localparam int         BEAT_LEN       = 5;

    localparam logic [4:0] MAX_PAYLOAD_RST = 5'd27;
    localparam logic [5:0] CHUNK_LIMIT_RST = 6'd32;

    // Heartbeat sent when a paired send slot finds the queue empty.
    localparam logic [7:0] HEARTBEAT [BEAT_LEN] = '{8'hA1, 8'hB1, 8'hC2, 8'hD1, 8'hE1};

endpackage

`default_nettype wire

// File: src/radio_frame_queue_tx.sv
// Top level: request sequencer, packet buffer, configuration and result register.
//
//  Channel  | Ports                | Contents
//  ---------+----------------------+-------------------------------------------
//  input    | s_tvalid/s_tready    | tdata: data_byte, link_paired; tuser: req_type
//  result   | m_tvalid/m_tready    | tdata: out_byte, out_status; tuser: out_kind;
//           |                      | tlast: out_last
//  config   | psel/penable/pwrite  | max_payload at 0x0, chunk_limit at 0x4
//
// A stored payload byte starts the bit-serial CRC unit, which holds s_tready
// low until its shift steps end. An end of packet that passes writes its frame
// into the queue, one byte a cycle through the single write port, then emits its
// status. A paired send slot drains one queued byte a cycle while the result side
// takes them, at most the chunk limit (zero counts as one). Reset is synchronous
// and leaves an empty queue; a low m_tready stalls the status, send and beat states.
`default_nettype none

module radio_frame_queue_tx
    import rfq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 256,
    parameter int PAYLOAD_BOUND = 27,
    parameter int CHUNK_BOUND   = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [8] link_paired, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [9:8] out_status, rest zero
    output logic             m_tlast,
    output logic [0:0]       m_tuser,   // [0] out_kind
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int PCW = $clog2(PAYLOAD_BOUND + 1);
    localparam int PIW = (PAYLOAD_BOUND > 1) ? $clog2(PAYLOAD_BOUND) : 1;
    localparam int FPW = $clog2(PAYLOAD_BOUND + FRAME_OVERHEAD);
    localparam int CLW = $clog2(CHUNK_BOUND + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FRAME  = 5'b00010,
        ST_STATUS = 5'b00100,
        ST_SEND   = 5'b01000,
        ST_BEAT   = 5'b10000
    } state_t;

    // Configuration registers.
    logic [4:0] max_payload_reg;
    logic [5:0] chunk_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            chunk_limit_reg <= CHUNK_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (rfq_reg_t'(paddr[2]))
                REG_MAX_PAYLOAD: max_payload_reg <= pwdata[4:0];
                REG_CHUNK_LIMIT: chunk_limit_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rfq_reg_t'(paddr[2]))
            REG_MAX_PAYLOAD: prdata = {27'd0, max_payload_reg};
            REG_CHUNK_LIMIT: prdata = {26'd0, chunk_limit_reg};
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Sequencer and working registers.
    state_t           state_reg, state_next;
    logic [PCW-1:0]   pay_count_reg, pay_count_next;
    logic             too_long_reg, too_long_next;
    logic [PCW-1:0]   frame_len_reg, frame_len_next;
    logic [7:0]       frame_crc_reg, frame_crc_next;
    logic [FPW-1:0]   pos_reg, pos_next;
    logic [CLW-1:0]   remain_reg, remain_next;
    logic [2:0]       beat_reg, beat_next;
    rfq_status_t      status_reg, status_next;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [1:0]       out_status_reg;
    logic             out_kind_reg;
    logic             out_last_reg;

    // Emission requested by the sequencer this cycle.
    logic             emit;
    logic [7:0]       emit_byte;
    rfq_status_t      emit_status;
    rfq_kind_t        emit_kind;
    logic             emit_last;
    logic             slot_free;

    // Submodule hookup.
    rfq_q_ctrl_t      q_ctrl;
    logic [7:0]       q_wr_data;
    logic [7:0]       q_rd_data;
    logic [QCW-1:0]   q_count;
    rfq_crc_ctrl_t    crc_ctrl;
    logic [7:0]       crc_val;
    logic             crc_busy;

    // Packet buffer.
    logic [7:0]       pay_mem [PAYLOAD_BOUND];
    logic [7:0]       pay_rd_reg;
    logic             pay_wr;
    logic [PIW-1:0]   pay_wr_addr;
    logic [PIW-1:0]   pay_rd_addr;
    logic [FPW-1:0]   pos_rd;

    // Decoded request fields.
    logic             accept;
    rfq_req_t         req;
    logic [7:0]       in_byte;
    logic             in_paired;

    // Helpers for the end-of-packet and send-slot decisions.
    logic [15:0]      len16;
    logic [CLW-1:0]   lim;
    logic [CLW-1:0]   n_send;
    logic [FPW-1:0]   crc_pos, last_pos;

    assign s_tready  = (state_reg == ST_IDLE) && !crc_busy;
    assign accept    = s_tvalid && s_tready;
    assign req       = rfq_req_t'(s_tuser);
    assign in_byte   = s_tdata[7:0];
    assign in_paired = s_tdata[8];
    assign slot_free = !out_valid_reg || m_tready;

    assign len16     = 16'(frame_len_reg);
    assign crc_pos   = FPW'(frame_len_reg) + FPW'(3);
    assign last_pos  = FPW'(frame_len_reg) + FPW'(4);

    // Effective chunk limit and the bytes this slot sends.
    always_comb begin
        if (chunk_limit_reg == 6'd0) begin
            lim = CLW'(1);
        end else if (32'(chunk_limit_reg) > CHUNK_BOUND) begin
            lim = CLW'(CHUNK_BOUND);
        end else begin
            lim = CLW'(chunk_limit_reg);
        end
        if (32'(q_count) < 32'(lim)) begin
            n_send = CLW'(q_count);
        end else begin
            n_send = lim;
        end
    end

    // Payload read address runs two places behind the frame position.
    always_comb begin
        pos_rd = pos_reg - FPW'(2);
        if (pos_reg >= FPW'(2) && 32'(pos_rd) < PAYLOAD_BOUND) begin
            pay_rd_addr = PIW'(pos_rd);
        end else begin
            pay_rd_addr = '0;
        end
    end

    // Main sequencer.
    always_comb begin
        state_next     = state_reg;
        pay_count_next = pay_count_reg;
        too_long_next  = too_long_reg;
        frame_len_next = frame_len_reg;
        frame_crc_next = frame_crc_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        beat_next      = beat_reg;
        status_next    = status_reg;
        emit           = 1'b0;
        emit_byte      = '0;
        emit_status    = STAT_QUEUED;
        emit_kind      = KIND_STATUS;
        emit_last      = 1'b0;
        q_ctrl         = '0;
        q_wr_data      = '0;
        crc_ctrl       = '0;
        pay_wr         = 1'b0;
        pay_wr_addr    = PIW'(pay_count_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (req)
                        REQ_BYTE: begin
                            if (32'(pay_count_reg) < PAYLOAD_BOUND) begin
                                pay_wr         = 1'b1;
                                pay_count_next = pay_count_reg + PCW'(1);
                                crc_ctrl.start = 1'b1;
                            end else begin
                                too_long_next = 1'b1;
                            end
                        end
                        REQ_EOP: begin
                            frame_len_next = pay_count_reg;
                            frame_crc_next = crc_val;
                            pos_next       = '0;
                            pay_count_next = '0;
                            too_long_next  = 1'b0;
                            crc_ctrl.clear = 1'b1;
                            if (too_long_reg ||
                                32'(pay_count_reg) > 32'(max_payload_reg)) begin
                                status_next = STAT_TOO_LONG;
                                state_next  = ST_STATUS;
                            end else if (32'(pay_count_reg) + FRAME_OVERHEAD >
                                         QUEUE_DEPTH - 32'(q_count)) begin
                                status_next = STAT_NO_ROOM;
                                state_next  = ST_STATUS;
                            end else begin
                                status_next = STAT_QUEUED;
                                state_next  = ST_FRAME;
                            end
                        end
                        REQ_SLOT: begin
                            if (in_paired) begin
                                if (n_send == '0) begin
                                    beat_next  = '0;
                                    state_next = ST_BEAT;
                                end else begin
                                    remain_next = n_send;
                                    state_next  = ST_SEND;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // One frame byte into the queue each cycle.
            ST_FRAME: begin
                q_ctrl.push = 1'b1;
                if (pos_reg == '0) begin
                    q_wr_data = FRAME_HEAD;
                end else if (pos_reg == FPW'(1)) begin
                    q_wr_data = len16[15:8];
                end else if (pos_reg == FPW'(2)) begin
                    q_wr_data = len16[7:0];
                end else if (pos_reg < crc_pos) begin
                    q_wr_data = pay_rd_reg;
                end else if (pos_reg == crc_pos) begin
                    q_wr_data = frame_crc_reg;
                end else begin
                    q_wr_data = FRAME_TAIL;
                end
                pos_next = pos_reg + FPW'(1);
                if (pos_reg == last_pos) begin
                    state_next = ST_STATUS;
                end
            end

            ST_STATUS: begin
                if (slot_free) begin
                    emit        = 1'b1;
                    emit_kind   = KIND_STATUS;
                    emit_status = status_reg;
                    state_next  = ST_IDLE;
                end
            end

            // Queued bytes, one per cycle while the result side takes them.
            ST_SEND: begin
                if (slot_free) begin
                    emit         = 1'b1;
                    emit_kind    = KIND_BYTE;
                    emit_byte    = q_rd_data;
                    emit_last    = (remain_reg == CLW'(1));
                    q_ctrl.pop   = 1'b1;
                    remain_next  = remain_reg - CLW'(1);
                    if (remain_reg == CLW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_BEAT: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_kind = KIND_BYTE;
                    emit_byte = HEARTBEAT[beat_reg];
                    emit_last = (beat_reg == 3'(BEAT_LEN - 1));
                    beat_next = beat_reg + 3'd1;
                    if (beat_reg == 3'(BEAT_LEN - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pay_count_reg <= '0;
            too_long_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pay_count_reg <= pay_count_next;
            too_long_reg  <= too_long_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        frame_len_reg <= frame_len_next;
        frame_crc_reg <= frame_crc_next;
        pos_reg       <= pos_next;
        remain_reg    <= remain_next;
        beat_reg      <= beat_next;
        status_reg    <= status_next;
    end

    // Packet buffer memory.
    always_ff @(posedge aclk) begin
        if (pay_wr) begin
            pay_mem[pay_wr_addr] <= in_byte;
        end
        pay_rd_reg <= pay_mem[pay_rd_addr];
    end

    // Result register, loaded whenever the sequencer emits.
    assign out_valid_next = emit || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_byte_reg   <= emit_byte;
            out_status_reg <= emit_status;
            out_kind_reg   <= emit_kind;
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

    rfq_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .data    (in_byte),
        .crc     (crc_val),
        .busy    (crc_busy)
    );

    rfq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .wr_data (q_wr_data),
        .rd_data (q_rd_data),
        .count   (q_count)
    );

endmodule

`default_nettype wire

// File: src/rfq_crc.sv
// Bit-serial CRC-8 (reflected 0x31) unit, one bit per cycle.
`default_nettype none

module rfq_crc
    import rfq_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rfq_crc_ctrl_t ctrl,
    input  wire logic [7:0]    data,
    output logic [7:0]         crc,
    output logic               busy
);

    logic [7:0] crc_reg, crc_next;
    logic       busy_reg, busy_next;
    logic [2:0] bit_reg, bit_next;

    // A clear resets the CRC; a start folds the byte in, then eight shift steps follow.
    always_comb begin
        crc_next  = crc_reg;
        busy_next = busy_reg;
        bit_next  = bit_reg;
        if (ctrl.clear) begin
            crc_next  = '0;
            busy_next = 1'b0;
            bit_next  = '0;
        end else if (ctrl.start) begin
            crc_next  = crc_reg ^ data;
            busy_next = 1'b1;
            bit_next  = '0;
        end else if (busy_reg) begin
            if (crc_reg[0]) begin
                crc_next = (crc_reg >> 1) ^ CRC_POLY_REFL;
            end else begin
                crc_next = crc_reg >> 1;
            end
            bit_next = bit_reg + 3'd1;
            if (bit_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= '0;
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end else begin
            crc_reg  <= crc_next;
            busy_reg <= busy_next;
            bit_reg  <= bit_next;
        end
    end

    assign crc  = crc_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

// File: src/rfq_queue.sv
// Byte queue: memory with head, tail and fill count, read-ahead output.
`default_nettype none

module rfq_queue
    import rfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire rfq_q_ctrl_t                      ctrl,
    input  wire logic [7:0]                       wr_data,
    output logic [7:0]                            rd_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);

    logic [7:0]    mem [QUEUE_DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_inc, tail_inc, rd_addr;
    logic [7:0]    rd_data_reg;

    // Pointer advance with wrap at any depth.
    always_comb begin
        head_inc = (head_reg == LAST_ADDR) ? '0 : head_reg + AW'(1);
        tail_inc = (tail_reg == LAST_ADDR) ? '0 : tail_reg + AW'(1);
        head_next  = ctrl.pop  ? head_inc : head_reg;
        tail_next  = ctrl.push ? tail_inc : tail_reg;
        count_next = count_reg;
        if (ctrl.push && !ctrl.pop) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.pop && !ctrl.push) begin
            count_next = count_reg - CW'(1);
        end
        // Read ahead so that the new head is on rd_data after a pop.
        rd_addr = head_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage, one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[tail_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

`default_nettype wire
